// ===== rtl/fmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared types and constants of the flow metering cache.
// ----------------------------------------------------------------------------
package fmc_pkg;

  localparam int unsigned TimeW = 48;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [TimeW-1:0] ScanGapMs = 48'd1000;

  localparam logic [0:0] RegInactive = 1'b0;
  localparam logic [0:0] RegActive   = 1'b1;

  localparam logic OpPacket = 1'b0;
  localparam logic OpExpire = 1'b1;

  typedef struct packed {
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [7:0]       protocol;
    logic [31:0]      ports;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [31:0]      packets;
    logic [63:0]      bytes;
    logic [TimeW-1:0] first_seen;
    logic [TimeW-1:0] last_seen;
    logic [15:0]      in_port;
    logic             direction;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/fmc_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmc_store
// Flow entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fmc_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire [AddrW-1:0]      waddr_i,
  input  wire fmc_pkg::entry_t wdata_i,
  input  wire [AddrW-1:0]      raddr_i,
  output fmc_pkg::entry_t      rdata_o
);

  fmc_pkg::entry_t mem_q [Depth];
  fmc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/flow_metering_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flow_metering_cache
// Fully associative flow cache with saturating counters and expiry export.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready). op=0 is a packet, op=1 an
// expiry request. Exported flows leave on the out channel, one item per
// flow, last set on the final one of a scan. Timeouts are written on the
// cfg channel (index 0 inactive, 1 active); the user must write them only
// while the block is idle, which the block itself does not enforce.
// Entries live in one memory with a registered read port; the key search
// walks it one slot per cycle and stops at a hit, and a new-flow packet
// is dropped when the table is full. An expiry request walks all slots
// unless it comes within ScanGapMs of the last scan. An export
// waits in the output register until taken and a second one in a holding
// register; the walk stalls only while both are full and the receiver is
// not ready. Reset clears the valid bits and the scan time and restores the
// default timeouts; the memory contents need no clearing.
// ----------------------------------------------------------------------------
module flow_metering_cache #(
  parameter int unsigned FLOW_ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         op_i,
  input  wire  [31:0] src_ip_i,
  input  wire  [31:0] dst_ip_i,
  input  wire  [7:0]  protocol_i,
  input  wire  [15:0] sport_i,
  input  wire  [15:0] dport_i,
  input  wire  [15:0] pkt_len_i,
  input  wire  [15:0] in_port_i,
  input  wire         direction_i,
  input  wire  [47:0] now_ms_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [0:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] flow_src_ip_o,
  output logic [31:0] flow_dst_ip_o,
  output logic [7:0]  flow_protocol_o,
  output logic [15:0] flow_sport_o,
  output logic [15:0] flow_dport_o,
  output logic [31:0] packet_count_o,
  output logic [63:0] byte_count_o,
  output logic [47:0] first_seen_o,
  output logic [47:0] last_seen_o,
  output logic [15:0] flow_in_port_o,
  output logic        flow_dir_o,
  output logic        last_o
);

  localparam int unsigned AddrW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned CntW  = AddrW + 1;
  localparam logic [CntW-1:0] NumEntries = CntW'(FLOW_ENTRIES);

  typedef enum logic [2:0] {
    StIdle, StRead, StCheck, StWrite, StScanRead, StScanCheck, StOut
  } state_e;

  state_e            state_q;
  fmc_pkg::key_t     key_q;
  logic [15:0]       len_q;
  logic [15:0]       in_port_q;
  logic              dir_q;
  logic [47:0]       now_q;
  logic [31:0]       inact_q;
  logic [31:0]       act_q;
  logic [47:0]       last_scan_q;
  logic [FLOW_ENTRIES-1:0] valid_q;
  logic [CntW-1:0]   rd_cnt_q;     // slot being read
  logic [AddrW-1:0]  hit_q;
  logic              free_found_q;
  logic [AddrW-1:0]  free_q;
  logic              have_pend_q;  // a held export waits for a later one
  fmc_pkg::entry_t   pend_q;
  fmc_pkg::entry_t   out_q;
  logic              out_valid_q;
  logic              out_last_q;

  logic              we;
  logic [AddrW-1:0]  waddr;
  fmc_pkg::entry_t   wdata;
  logic [AddrW-1:0]  raddr;
  fmc_pkg::entry_t   rdata;
  logic [AddrW-1:0]  cur;
  logic              cur_valid;
  logic              key_hit;
  logic              expired;
  logic              scan_hold;
  logic [47:0]       idle_ms;
  logic [47:0]       age_ms;
  logic [64:0]       bytes_sum;
  logic [31:0]       ports_in;

  assign cur       = rd_cnt_q[AddrW-1:0] - AddrW'(1);
  assign cur_valid = valid_q[cur];
  assign key_hit   = cur_valid && (rdata.key == key_q);
  assign idle_ms   = now_q - rdata.last_seen;
  assign age_ms    = now_q - rdata.first_seen;
  assign expired   = (idle_ms > {16'd0, inact_q}) || (age_ms > {16'd0, act_q});
  assign bytes_sum = {1'b0, rdata.bytes} + {49'd0, len_q};
  assign scan_hold = (state_q == StScanCheck) && have_pend_q && out_valid_q &&
                     !out_ready_i;
  // a held walk re-reads the current slot
  assign raddr     = scan_hold ? cur : rd_cnt_q[AddrW-1:0];
  assign ports_in  = ((protocol_i == fmc_pkg::ProtoTcp) ||
                      (protocol_i == fmc_pkg::ProtoUdp)) ?
                     {sport_i, dport_i} : 32'd0;

  always_comb begin
    we    = 1'b0;
    waddr = hit_q;
    wdata = rdata;
    if (state_q == StWrite) begin
      we = (rd_cnt_q == '0);
      if (free_found_q && (rd_cnt_q == '0)) begin
        waddr            = free_q;
        wdata.key        = key_q;
        wdata.packets    = 32'd1;
        wdata.bytes      = {48'd0, len_q};
        wdata.first_seen = now_q;
        wdata.last_seen  = now_q;
        wdata.in_port    = in_port_q;
        wdata.direction  = dir_q;
      end else begin
        if (rdata.packets != '1) begin
          wdata.packets = rdata.packets + 32'd1;
        end
        wdata.bytes     = bytes_sum[64] ? '1 : bytes_sum[63:0];
        wdata.last_seen = now_q;
      end
    end
  end

  fmc_store #(.Depth(FLOW_ENTRIES), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (state_q == StWrite ? hit_q : raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;

  // StWrite: hit path reads the hit slot first (rd_cnt_q != 0 marks it).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      last_scan_q  <= '0;
      inact_q      <= 32'd15000;
      act_q        <= 32'd1800000;
      rd_cnt_q     <= '0;
      free_found_q <= 1'b0;
      have_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fmc_pkg::RegInactive: inact_q <= cfg_data_i;
          fmc_pkg::RegActive:   act_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            key_q        <= '{src_ip: src_ip_i, dst_ip: dst_ip_i,
                              protocol: protocol_i, ports: ports_in};
            len_q        <= pkt_len_i;
            in_port_q    <= in_port_i;
            dir_q        <= direction_i;
            now_q        <= now_ms_i;
            free_found_q <= 1'b0;
            have_pend_q  <= 1'b0;
            rd_cnt_q     <= '0;
            if (op_i == fmc_pkg::OpPacket) begin
              state_q <= StRead;
            end else if ((now_ms_i - last_scan_q) < fmc_pkg::ScanGapMs) begin
              state_q <= StOut;
              rd_cnt_q <= NumEntries + CntW'(1);
            end else begin
              last_scan_q <= now_ms_i;
              state_q     <= StScanRead;
            end
          end
        end
        StRead: begin
          rd_cnt_q <= rd_cnt_q + CntW'(1);
          state_q  <= StCheck;
        end
        StCheck: begin
          // rdata holds slot cur
          if (key_hit) begin
            hit_q    <= cur;
            rd_cnt_q <= CntW'(1);
            state_q  <= StWrite;
          end else begin
            if (!cur_valid && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= cur;
            end
            if (rd_cnt_q == NumEntries) begin
              rd_cnt_q <= '0;
              if (!cur_valid || free_found_q) begin
                state_q <= StWrite;
                if (!free_found_q) free_q <= cur;
                free_found_q <= 1'b1;
              end else begin
                state_q <= StIdle;
              end
            end else begin
              rd_cnt_q <= rd_cnt_q + CntW'(1);
            end
          end
        end
        StWrite: begin
          if (rd_cnt_q != '0) begin
            rd_cnt_q <= '0;
            free_found_q <= 1'b0;   // second pass performs the update
          end else begin
            if (free_found_q) valid_q[free_q] <= 1'b1;
            state_q <= StIdle;
          end
        end
        StScanRead: begin
          rd_cnt_q <= rd_cnt_q + CntW'(1);
          state_q  <= StScanCheck;
        end
        StScanCheck: begin
          if (!scan_hold) begin
            if (cur_valid && expired) begin
              valid_q[cur] <= 1'b0;
              if (have_pend_q) begin
                out_q       <= pend_q;
                out_last_q  <= 1'b0;
                out_valid_q <= 1'b1;
              end
              pend_q      <= rdata;
              have_pend_q <= 1'b1;
            end
            if (rd_cnt_q == NumEntries) begin
              rd_cnt_q <= NumEntries + CntW'(1);
              state_q  <= StOut;
            end else begin
              rd_cnt_q <= rd_cnt_q + CntW'(1);
            end
          end else begin
            rd_cnt_q <= rd_cnt_q;
          end
        end
        StOut: begin
          if (!have_pend_q) begin
            state_q <= StIdle;
          end else if (!out_valid_q || out_ready_i) begin
            out_q       <= pend_q;
            out_last_q  <= 1'b1;
            out_valid_q <= 1'b1;
            have_pend_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flow_src_ip_o    = out_q.key.src_ip;
  assign flow_dst_ip_o    = out_q.key.dst_ip;
  assign flow_protocol_o  = out_q.key.protocol;
  assign flow_sport_o     = out_q.key.ports[31:16];
  assign flow_dport_o     = out_q.key.ports[15:0];
  assign packet_count_o   = out_q.packets;
  assign byte_count_o     = out_q.bytes;
  assign first_seen_o     = out_q.first_seen;
  assign last_seen_o      = out_q.last_seen;
  assign flow_in_port_o   = out_q.in_port;
  assign flow_dir_o       = out_q.direction;
  assign last_o           = out_last_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("export item changed while stalled");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !have_pend_q)
    else $error("pending export left behind");
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> state_q == StWrite)
    else $error("memory write outside update");
`endif

endmodule
`default_nettype wire
